// ===== rtl/ddrm_pkg.sv =====
`timescale 1ns / 1ps

package ddrm_pkg;

  // H-bridge direction codes
  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_FWD  = 2'd1,
    DRIVE_REV  = 2'd2
  } drive_t;

  // Request source codes
  localparam logic OP_PAD    = 1'b0;
  localparam logic OP_SENSOR = 1'b1;

  // Active-low gamepad button positions
  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_DOWN  = 2;
  localparam int BTN_UP    = 3;
  localparam int BTN_START = 4;

  localparam logic signed [7:0] FULL_POS = 8'sd127;
  localparam logic signed [7:0] FULL_NEG = -8'sd127;
  localparam logic signed [7:0] CRUISE   = 8'sd80;
  localparam logic signed [7:0] HALF_POS = 8'sd64;
  localparam logic signed [7:0] HALF_NEG = -8'sd64;

  typedef struct packed {
    logic signed [7:0] speed;
    logic signed [7:0] turn;
  } target_t;

  // Steering table for the line detector pattern
  function automatic target_t sensor_target(input logic [3:0] pat);
    target_t t;
    t.speed = 8'sd0;
    t.turn  = 8'sd0;
    case (pat)
      4'b0110: begin t.speed = FULL_POS; t.turn = 8'sd0;    end
      4'b0100: begin t.speed = FULL_POS; t.turn = HALF_NEG; end
      4'b1100: begin t.speed = CRUISE;   t.turn = HALF_NEG; end
      4'b1000: begin t.speed = 8'sd0;    t.turn = FULL_NEG; end
      4'b1110: begin t.speed = 8'sd0;    t.turn = FULL_NEG; end
      4'b0010: begin t.speed = FULL_POS; t.turn = HALF_POS; end
      4'b0011: begin t.speed = CRUISE;   t.turn = HALF_POS; end
      4'b0001: begin t.speed = 8'sd0;    t.turn = FULL_POS; end
      4'b0111: begin t.speed = 8'sd0;    t.turn = FULL_POS; end
      4'b0000: begin t.speed = CRUISE;   t.turn = 8'sd0;    end
      4'b1111: begin t.speed = FULL_POS; t.turn = 8'sd0;    end
      default: begin t.speed = 8'sd0;    t.turn = 8'sd0;    end
    endcase
    return t;
  endfunction

  // Step one count toward the target
  function automatic logic signed [7:0] ramp_step(input logic signed [7:0] cur,
                                                  input logic signed [7:0] tgt);
    logic signed [7:0] res;
    res = cur;
    if (cur > tgt) begin
      res = cur - 8'sd1;
    end else if (cur < tgt) begin
      res = cur + 8'sd1;
    end
    return res;
  endfunction

  // Limit a mixed value to the motor range
  function automatic logic signed [7:0] clamp_level(input logic signed [9:0] v);
    logic signed [7:0] res;
    if (v > 10'sd127) begin
      res = FULL_POS;
    end else if (v < -10'sd127) begin
      res = FULL_NEG;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  function automatic drive_t drive_code(input logic signed [7:0] v);
    drive_t res;
    if (v > 8'sd0) begin
      res = DRIVE_FWD;
    end else if (v < 8'sd0) begin
      res = DRIVE_REV;
    end else begin
      res = DRIVE_STOP;
    end
    return res;
  endfunction

  // PWM compare value: twice the magnitude
  function automatic logic [7:0] duty_of(input logic signed [7:0] v);
    logic [7:0] mag;
    mag = v[7] ? 8'(-v) : 8'(v);
    return {mag[6:0], 1'b0};
  endfunction

endpackage

// ===== rtl/differential_drive_ramp_mixer.sv =====
`timescale 1ns / 1ps

// Differential-drive ramp mixer. Each request is a gamepad tick (active-low
// up/down/left/right/start) or a line-sensor tick (4-bit pattern looked up in a
// steering table); either sets a target speed and turn, and the held speed and
// turn step by one toward them. The two are mixed into left and right levels in
// -127..127, giving an H-bridge code and a PWM duty of twice the magnitude per
// motor. A gamepad start press changes nothing and raises out_stop_requested,
// with the held levels shown. One request is taken every cycle while no result
// stalls; each passes the input register, the ramp stage register and the mix
// stage (one 7x7 multiplier and a divide by 127 done by shift and add) into the
// result register. A stalled result holds the whole pipe and stalls the input.
module differential_drive_ramp_mixer (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_op,
  input  logic [7:0]             in_pad_buttons,
  input  logic [3:0]             in_line_sensors,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ddrm_pkg::drive_t       out_left_drive,
  output ddrm_pkg::drive_t       out_right_drive,
  output logic [7:0]             out_left_duty,
  output logic [7:0]             out_right_duty,
  output logic                   out_stop_requested
);

  import ddrm_pkg::*;

  logic adv;

  // Input register
  logic       a_valid_r;
  logic       a_op_r;
  logic [7:0] a_pad_r;
  logic [3:0] a_sens_r;

  // Ramp stage register
  logic              b_valid_r;
  logic              b_stop_r;
  logic signed [7:0] b_s_r;
  logic signed [7:0] b_d_r;

  // Held state
  logic signed [7:0] speed_r, speed_nxt;
  logic signed [7:0] turn_r, turn_nxt;
  logic signed [7:0] left_level_r, left_level_nxt;
  logic signed [7:0] right_level_r, right_level_nxt;

  // Result register
  logic       out_valid_r;
  drive_t     out_left_drive_r, out_right_drive_r;
  logic [7:0] out_left_duty_r, out_right_duty_r;
  logic       out_stop_r;

  // Move the whole pipe unless a result waits on a stalled receiver
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Capture the request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r <= in_valid;
    end
    if (adv) begin
      a_op_r   <= in_op;
      a_pad_r  <= in_pad_buttons;
      a_sens_r <= in_line_sensors;
    end
  end

  // Decode the target and ramp speed and turn
  logic    stop_req;
  target_t tgt;

  always_comb begin
    stop_req = 1'b0;
    tgt      = sensor_target(a_sens_r);
    if (a_op_r == OP_PAD) begin
      stop_req   = !a_pad_r[BTN_START];
      tgt.speed  = 8'sd0;
      tgt.turn   = 8'sd0;
      if (!a_pad_r[BTN_UP]) begin
        tgt.speed = FULL_POS;
      end
      if (!a_pad_r[BTN_DOWN]) begin
        tgt.speed = FULL_NEG;
      end
      if (!a_pad_r[BTN_LEFT]) begin
        tgt.turn = FULL_NEG;
      end
      if (!a_pad_r[BTN_RIGHT]) begin
        tgt.turn = FULL_POS;
      end
    end
    speed_nxt = ramp_step(speed_r, tgt.speed);
    turn_nxt  = ramp_step(turn_r, tgt.turn);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      speed_r   <= 8'sd0;
      turn_r    <= 8'sd0;
    end else if (adv) begin
      b_valid_r <= a_valid_r;
      if (a_valid_r && !stop_req) begin
        speed_r <= speed_nxt;
        turn_r  <= turn_nxt;
      end
    end
    if (adv) begin
      b_stop_r <= stop_req;
      b_s_r    <= speed_nxt;
      b_d_r    <= turn_nxt;
    end
  end

  // Mix speed and turn into motor levels
  logic [6:0]        d_mag;
  logic [6:0]        inner;
  logic [13:0]       prod;
  logic [14:0]       quot_sum;
  logic signed [9:0] scaled;
  logic signed [9:0] s_w, d_w;
  logic signed [9:0] l_mix, r_mix;

  always_comb begin
    d_mag    = b_d_r[7] ? 7'(-b_d_r) : b_d_r[6:0];
    inner    = 7'd127 - d_mag;
    prod     = 14'(b_s_r[6:0]) * 14'(inner);
    // exact divide by 127 for every product here (at most 127*127)
    quot_sum = 15'(prod) + 15'(prod >> 7) + 15'd1;
    scaled   = 10'($unsigned(quot_sum[13:7]));
    s_w      = 10'(b_s_r);
    d_w      = 10'(b_d_r);
    l_mix    = s_w;
    r_mix    = s_w;
    if (b_d_r != 8'sd0) begin
      if (!b_s_r[7]) begin
        if (b_d_r[7]) begin
          l_mix = s_w + d_w;
          r_mix = scaled - d_w;
        end else begin
          r_mix = s_w - d_w;
          l_mix = scaled + d_w;
        end
      end else begin
        if (b_d_r[7]) begin
          r_mix = s_w - d_w;
        end else begin
          l_mix = s_w + d_w;
        end
      end
    end
    if (b_stop_r) begin
      left_level_nxt  = left_level_r;
      right_level_nxt = right_level_r;
    end else begin
      left_level_nxt  = clamp_level(l_mix);
      right_level_nxt = clamp_level(r_mix);
    end
  end

  // Hold the levels and register the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      left_level_r  <= 8'sd0;
      right_level_r <= 8'sd0;
    end else if (adv) begin
      out_valid_r <= b_valid_r;
      if (b_valid_r) begin
        left_level_r  <= left_level_nxt;
        right_level_r <= right_level_nxt;
      end
    end
    if (adv) begin
      out_left_drive_r  <= drive_code(left_level_nxt);
      out_right_drive_r <= drive_code(right_level_nxt);
      out_left_duty_r   <= duty_of(left_level_nxt);
      out_right_duty_r  <= duty_of(right_level_nxt);
      out_stop_r        <= b_stop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_drive     = out_left_drive_r;
  assign out_right_drive    = out_right_drive_r;
  assign out_left_duty      = out_left_duty_r;
  assign out_right_duty     = out_right_duty_r;
  assign out_stop_requested = out_stop_r;

endmodule

// ===== verif/tb_differential_drive_ramp_mixer.sv =====
`timescale 1ns / 1ps

// One expected motor result, field for field as the block reports it
typedef struct {
  ddrm_pkg::drive_t left_drive;
  ddrm_pkg::drive_t right_drive;
  logic [7:0]       left_duty;
  logic [7:0]       right_duty;
  logic             stop_requested;
} motor_result_t;

// Tracks the ramped speed/turn and mixed levels, and the results they predict
class drive_scoreboard;
  logic signed [7:0] speed_now   = '0;
  logic signed [7:0] turn_now    = '0;
  logic signed [7:0] left_level  = '0;
  logic signed [7:0] right_level = '0;
  motor_result_t     expected_results[$];
  int                requests_seen   = 0;
  int                sensor_requests = 0;
  int                stop_requests   = 0;
  int                results_checked = 0;
  int                mismatches      = 0;
  int                lowest_speed    = 0;
  int                highest_speed   = 0;

  // Advance one count toward the target
  function automatic logic signed [7:0] step_toward(logic signed [7:0] cur, int tgt);
    int c;
    c = cur;
    if (c > tgt) begin
      c = c - 1;
    end else if (c < tgt) begin
      c = c + 1;
    end
    return 8'(c);
  endfunction

  function automatic logic signed [7:0] limit_level(int v);
    int c;
    c = v;
    if (c > 127) c = 127;
    if (c < -127) c = -127;
    return 8'(c);
  endfunction

  function automatic ddrm_pkg::drive_t bridge_for(logic signed [7:0] v);
    ddrm_pkg::drive_t code;
    code = ddrm_pkg::DRIVE_STOP;
    if (v > 0) code = ddrm_pkg::DRIVE_FWD;
    if (v < 0) code = ddrm_pkg::DRIVE_REV;
    return code;
  endfunction

  function automatic logic [7:0] pwm_for(logic signed [7:0] v);
    int mag;
    mag = (v < 0) ? -int'(v) : int'(v);
    return 8'(2 * mag);
  endfunction

  // Work out the result of one accepted request and queue it
  function void note_request(logic op, logic [7:0] buttons, logic [3:0] pattern);
    int            tgt_speed;
    int            tgt_turn;
    int            s;
    int            d;
    int            l;
    int            r;
    bit            stop;
    motor_result_t want;
    tgt_speed = 0;
    tgt_turn  = 0;
    stop      = 1'b0;
    requests_seen++;
    if (op == ddrm_pkg::OP_PAD) begin
      if (!buttons[ddrm_pkg::BTN_START]) begin
        stop = 1'b1;
      end else begin
        // down beats up, right beats left
        if (!buttons[ddrm_pkg::BTN_UP]) tgt_speed = ddrm_pkg::FULL_POS;
        if (!buttons[ddrm_pkg::BTN_DOWN]) tgt_speed = ddrm_pkg::FULL_NEG;
        if (!buttons[ddrm_pkg::BTN_LEFT]) tgt_turn = ddrm_pkg::FULL_NEG;
        if (!buttons[ddrm_pkg::BTN_RIGHT]) tgt_turn = ddrm_pkg::FULL_POS;
      end
    end else begin
      sensor_requests++;
      case (pattern)
        4'b0110: begin tgt_speed = ddrm_pkg::FULL_POS; tgt_turn = 0;                  end
        4'b0100: begin tgt_speed = ddrm_pkg::FULL_POS; tgt_turn = ddrm_pkg::HALF_NEG; end
        4'b1100: begin tgt_speed = ddrm_pkg::CRUISE;   tgt_turn = ddrm_pkg::HALF_NEG; end
        4'b1000: begin tgt_speed = 0;                  tgt_turn = ddrm_pkg::FULL_NEG; end
        4'b1110: begin tgt_speed = 0;                  tgt_turn = ddrm_pkg::FULL_NEG; end
        4'b0010: begin tgt_speed = ddrm_pkg::FULL_POS; tgt_turn = ddrm_pkg::HALF_POS; end
        4'b0011: begin tgt_speed = ddrm_pkg::CRUISE;   tgt_turn = ddrm_pkg::HALF_POS; end
        4'b0001: begin tgt_speed = 0;                  tgt_turn = ddrm_pkg::FULL_POS; end
        4'b0111: begin tgt_speed = 0;                  tgt_turn = ddrm_pkg::FULL_POS; end
        4'b0000: begin tgt_speed = ddrm_pkg::CRUISE;   tgt_turn = 0;                  end
        4'b1111: begin tgt_speed = ddrm_pkg::FULL_POS; tgt_turn = 0;                  end
        default: begin tgt_speed = 0;                  tgt_turn = 0;                  end
      endcase
    end

    // Start held: freeze the state and show the held levels
    if (stop) begin
      stop_requests++;
    end else begin
      speed_now = step_toward(speed_now, tgt_speed);
      turn_now  = step_toward(turn_now, tgt_turn);
      s = speed_now;
      d = turn_now;
      if (s < lowest_speed) lowest_speed = s;
      if (s > highest_speed) highest_speed = s;
      // Forward turns scale the outer wheel; reverse turns slow the inner one
      if (d == 0) begin
        l = s;
        r = s;
      end else if (s >= 0) begin
        if (d < 0) begin
          l = s + d;
          r = (s * (127 + d)) / 127 - d;
        end else begin
          r = s - d;
          l = (s * (127 - d)) / 127 + d;
        end
      end else begin
        if (d < 0) begin
          r = s - d;
          l = s;
        end else begin
          l = s + d;
          r = s;
        end
      end
      left_level  = limit_level(l);
      right_level = limit_level(r);
    end

    want.left_drive     = bridge_for(left_level);
    want.right_drive    = bridge_for(right_level);
    want.left_duty      = pwm_for(left_level);
    want.right_duty     = pwm_for(right_level);
    want.stop_requested = stop;
    expected_results.push_back(want);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(ddrm_pkg::drive_t left_drive, ddrm_pkg::drive_t right_drive,
                             logic [7:0] left_duty, logic [7:0] right_duty,
                             logic stop_requested);
    motor_result_t want;
    if (expected_results.size() == 0) begin
      mismatches++;
      $display("%0t: result with no request pending, actual %0d %0d %0d %0d %0d", $time,
               left_drive, right_drive, left_duty, right_duty, stop_requested);
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      compare_field("left_drive", 8'(want.left_drive), 8'(left_drive));
      compare_field("right_drive", 8'(want.right_drive), 8'(right_drive));
      compare_field("left_duty", want.left_duty, left_duty);
      compare_field("right_duty", want.right_duty, right_duty);
      compare_field("stop_requested", 8'(want.stop_requested), 8'(stop_requested));
    end
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb_differential_drive_ramp_mixer;
  import ddrm_pkg::*;

  localparam int RANDOM_REQUESTS = 2000;

  logic       clk                = 1'b0;
  logic       rst_n              = 1'b0;
  logic       in_valid           = 1'b0;
  logic       in_op              = OP_PAD;
  logic [7:0] in_pad_buttons     = 8'hFF;
  logic [3:0] in_line_sensors    = 4'h0;
  logic       out_stall          = 1'b0;
  logic       in_stall;
  logic       out_valid;
  drive_t     out_left_drive;
  drive_t     out_right_drive;
  logic [7:0] out_left_duty;
  logic [7:0] out_right_duty;
  logic       out_stop_requested;

  drive_scoreboard board = new();

  int stall_left = 0;
  bit stall_mode = 1'b0;

  differential_drive_ramp_mixer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_pad_buttons     (in_pad_buttons),
    .in_line_sensors    (in_line_sensors),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_left_drive     (out_left_drive),
    .out_right_drive    (out_right_drive),
    .out_left_duty      (out_left_duty),
    .out_right_duty     (out_right_duty),
    .out_stop_requested (out_stop_requested)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hold the result stall in runs: short stalls, a few long ones, quiet stretches
  always @(posedge clk) begin
    int pick;
    if (stall_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        stall_mode = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (pick < 85) begin
        stall_mode = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else if (pick < 95) begin
        stall_mode = 1'b1;
        stall_left = $urandom_range(4, 12);
      end else begin
        stall_mode = 1'b0;
        stall_left = $urandom_range(30, 80);
      end
    end
    stall_left = stall_left - 1;
    out_stall <= stall_mode;
  end

  // Note accepted requests before checking results taken at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        board.note_request(in_op, in_pad_buttons, in_line_sensors);
      end
      if (out_valid && !out_stall) begin
        board.check_result(out_left_drive, out_right_drive, out_left_duty, out_right_duty,
                           out_stop_requested);
      end
    end
  end

  function automatic int pick_gap(bit quiet);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap  = 0;
    if (quiet || pick < 60) begin
      gap = 0;
    end else if (pick < 90) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 40);
    end
    return gap;
  endfunction

  // Present one request after an idle gap and wait until it is taken
  task automatic send_request(input logic op, input logic [7:0] buttons,
                              input logic [3:0] pattern, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_pad_buttons  <= buttons;
    in_line_sensors <= pattern;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [7:0] held_buttons;
    logic [7:0] buttons;
    logic [3:0] held_pattern;
    logic [3:0] pattern;
    logic       op;
    int         sent;
    int         run_len;
    int         kind;
    bit         quiet;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle pad, start alone and with everything, each direction and conflict
    send_request(OP_PAD, 8'hFF, 4'h0, 0);
    send_request(OP_PAD, 8'hEF, 4'hF, 0);
    send_request(OP_PAD, 8'h00, 4'h5, 1);
    send_request(OP_PAD, 8'hF7, 4'h0, 0);
    send_request(OP_PAD, 8'hF3, 4'hA, 0);
    send_request(OP_PAD, 8'hFD, 4'h0, 2);
    send_request(OP_PAD, 8'hFE, 4'h0, 0);
    send_request(OP_PAD, 8'hFC, 4'h0, 0);
    send_request(OP_PAD, 8'h1B, 4'hF, 0);
    send_request(OP_PAD, 8'hEB, 4'h0, 0);
    // Every steering pattern, with the pad bits both ways
    for (int p = 0; p < 16; p++) begin
      send_request(OP_SENSOR, (p % 2 == 0) ? 8'h00 : 8'hFF, 4'(p), pick_gap(1'b0));
    end

    // Random: held commands so the ramps reach their ends, plus noise
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                              : $urandom_range(1, 40);
      quiet        = ($urandom_range(0, 3) == 0);
      kind         = $urandom_range(0, 99);
      held_buttons = 8'($urandom_range(0, 255));
      held_buttons[BTN_START] = 1'b1;
      held_pattern = 4'($urandom_range(0, 15));
      for (int i = 0; i < run_len && sent < RANDOM_REQUESTS; i++) begin
        buttons = 8'($urandom_range(0, 255));
        pattern = 4'($urandom_range(0, 15));
        if (kind < 45) begin
          op = OP_PAD;
          buttons[4:0] = held_buttons[4:0];
          if ($urandom_range(0, 40) == 0) buttons[BTN_START] = 1'b0;
        end else if (kind < 85) begin
          op = OP_SENSOR;
          pattern = held_pattern;
        end else begin
          op = 1'($urandom_range(0, 1));
        end
        send_request(op, buttons, pattern, pick_gap(quiet));
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain, then give the pipeline time to show any stray result
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests (%0d from the line sensor, %0d with start held); %0d results",
             board.requests_seen, board.sensor_requests, board.stop_requests,
             board.results_checked);
    $display("Ramped speed covered %0d..%0d", board.lowest_speed, board.highest_speed);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Give up on a hung handshake
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule
